// ===== src/wsd_pkg.sv =====
// shared types and constants for the window sample standard deviation block
// no dependencies
package wsd_pkg;

	localparam int WINDOW_MAX = 256;
	localparam int SLOT_W     = $clog2(WINDOW_MAX);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int SAMPLE_W   = 32;
	localparam int DEV_W      = 32;
	localparam int SUM1_W     = SAMPLE_W + SLOT_W;        // sum of samples
	localparam int SUM2_W     = 2 * SAMPLE_W + SLOT_W;    // sum of squares
	localparam int NUM_W      = SUM2_W + CNT_W;           // n * sum of squares
	localparam int DEN_W      = 2 * SLOT_W;               // n * (n - 1)
	localparam int SQ_IN_W    = 2 * DEV_W;                // radicand width
	localparam int WLEN_RESET = 20;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} in_t;

	typedef struct packed {
		logic [DEV_W-1:0] deviation;
		logic [CNT_W-1:0] samples_used;
		logic             status;
	} out_t;

endpackage

// ===== src/wsd_ram.sv =====
// sample ring storage: one write port, one read port, registered read data
// no dependencies
module wsd_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/wsd_divsqrt.sv =====
// serial divide by n*(n-1) followed by a two-bit-per-step integer square root
// depends on wsd_pkg
module wsd_divsqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wsd_pkg::NUM_W-1:0] num,
	input  logic [wsd_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [wsd_pkg::DEV_W-1:0] root
);
	import wsd_pkg::*;

	localparam int STEP_W = $clog2(NUM_W);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [NUM_W-1:0]   dq_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [SQ_IN_W-1:0] op_q;
	logic [DEV_W+3:0]   srem_q;
	logic [DEV_W-1:0]   root_q;

	logic [DEN_W:0]   dcur, ddiff;
	logic             dge;
	logic [DEV_W+3:0] scur, strial;
	logic             sge;

	always_comb begin
		dcur   = {rem_q, dq_q[NUM_W-1]};
		ddiff  = dcur - {1'b0, den_q};
		dge    = dcur >= {1'b0, den_q};
		scur   = {srem_q[DEV_W+1:0], op_q[SQ_IN_W-1 -: 2]};
		strial = {2'b00, root_q, 2'b01};
		sge    = scur >= strial;
	end

	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(NUM_W - 1)) begin
						state_q <= ST_SQRT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(DEV_W - 1)) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dq_q  <= num;
				den_q <= den;
				rem_q <= '0;
			end
			ST_DIV: begin
				dq_q  <= {dq_q[NUM_W-2:0], dge};
				rem_q <= dge ? ddiff[DEN_W-1:0] : dcur[DEN_W-1:0];
				if (step_q == STEP_W'(NUM_W - 1)) begin
					// quotient is known to fit the radicand width
					op_q   <= {dq_q[SQ_IN_W-2:0], dge};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				op_q   <= {op_q[SQ_IN_W-3:0], 2'b00};
				srem_q <= sge ? scur - strial : scur;
				root_q <= {root_q[DEV_W-2:0], sge};
			end
			default: ;
		endcase
	end

endmodule

// ===== src/window_sample_std_deviation.sv =====
// top level of the window sample standard deviation block
// depends on wsd_pkg, wsd_ram, wsd_divsqrt
//
// usage:
//  - item channel (item_valid/item_ready/item): each request carries one
//    sample and a last flag. a sample without last is written to the ring,
//    so loading runs at one request per cycle while no set is being closed.
//  - a request with last closes the set: the newest n = min(window_len,
//    loaded) samples are read back one per cycle from the ring memory,
//    squared and summed, then n*sum(x^2) - (sum x)^2 is formed, divided by
//    n*(n-1) in a bit-serial divider and passed through a two-bit-per-step
//    square root. fewer than two samples give deviation 0, status 1.
//  - cfg_we/cfg_wdata write window_len (reset 20); the user must write
//    it only while the block is idle, since the block itself does not
//    enforce this.
//  - result channel (result_valid/result_ready/result) is a register: new
//    samples are still accepted while a result waits; a later last request
//    holds its result until the register is free.
//  - reset clears the load count, write slot and control; ring contents
//    are not cleared since an entry is read only after it was written.
module window_sample_std_deviation (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  wsd_pkg::in_t                 item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output wsd_pkg::out_t                result,
	input  logic                         cfg_we,
	input  logic [wsd_pkg::CNT_W-1:0]    cfg_wdata
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {ST_LOAD, ST_ACC, ST_MUL, ST_SUB, ST_DIV, ST_FIN} state_t;

	localparam int HALF_W = SUM1_W - SAMPLE_W;

	state_t            state_q;
	logic [CNT_W-1:0]  wlen_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  loaded_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  issue_q;
	logic              rd_v_s1;
	logic              v_s2;
	logic [SAMPLE_W-1:0]   x_s2;
	logic [2*SAMPLE_W-1:0] sq_s2;
	logic [SUM1_W-1:0] s1_q;
	logic [SUM2_W-1:0] s2_q;
	logic [NUM_W-1:0]  pns_q;
	logic [2*SAMPLE_W-1:0] pll_q;
	logic [SUM1_W-1:0] phl_q;
	logic [2*HALF_W-1:0] phh_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic              div_start_q;
	logic              div_done;
	logic [DEV_W-1:0]  div_root;
	logic [DEV_W-1:0]  dev_q;
	out_t              result_q;
	logic              result_valid_q;

	logic              accept;
	logic [CNT_W-1:0]  loaded_nx;
	logic [CNT_W-1:0]  wlen_sat;
	logic [CNT_W-1:0]  n_nx;
	logic [SLOT_W-1:0] raddr;
	logic [SAMPLE_W-1:0] rdata;
	logic              issuing;
	logic              out_free;
	logic [NUM_W-1:0]  s1sq;

	assign item_ready   = (state_q == ST_LOAD);
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	always_comb begin
		// load count after this request, saturating at ring depth
		loaded_nx = (loaded_q < CNT_W'(WINDOW_MAX)) ? loaded_q + 1'b1 : loaded_q;
		wlen_sat  = (wlen_q > CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : wlen_q;
		n_nx      = (wlen_sat < loaded_nx) ? wlen_sat : loaded_nx;
		// walk back from the newest sample
		raddr     = slot_q - SLOT_W'(1) - issue_q[SLOT_W-1:0];
		issuing   = (state_q == ST_ACC) && (issue_q != n_q);
		// (sum x)^2 from its low word and high byte partial products
		s1sq      = NUM_W'(pll_q) + (NUM_W'(phl_q) << (SAMPLE_W + 1))
		          + (NUM_W'(phh_q) << (2 * SAMPLE_W));
	end

	// the ring is never written while it is walked, so no forwarding is needed
	wsd_ram #(
		.ADDR_W(SLOT_W),
		.DATA_W(SAMPLE_W)
	) u_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(slot_q),
		.wdata(item.sample),
		.raddr(raddr),
		.rdata(rdata)
	);

	wsd_divsqrt u_divsqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (num_q),
		.den   (den_q),
		.done  (div_done),
		.root  (div_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			wlen_q         <= CNT_W'(WLEN_RESET);
			slot_q         <= '0;
			loaded_q       <= '0;
			issue_q        <= '0;
			rd_v_s1        <= 1'b0;
			v_s2           <= 1'b0;
			div_start_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			rd_v_s1     <= issuing;
			v_s2        <= rd_v_s1;
			if (cfg_we) begin
				wlen_q <= cfg_wdata;
			end
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						slot_q   <= slot_q + 1'b1;
						loaded_q <= loaded_nx;
						if (item.last) begin
							loaded_q <= '0;
							issue_q  <= '0;
							// fewer than two samples skips the arithmetic
							state_q  <= (n_nx < CNT_W'(2)) ? ST_FIN : ST_ACC;
						end
					end
				end
				ST_ACC: begin
					if (issuing) begin
						issue_q <= issue_q + 1'b1;
					end else if (!rd_v_s1 && !v_s2) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUB;
				ST_SUB: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept && item.last) begin
			n_q   <= n_nx;
			dev_q <= '0;
			s1_q  <= '0;
			s2_q  <= '0;
		end
		// square stage
		x_s2  <= rdata;
		sq_s2 <= rdata * rdata;
		if (v_s2) begin
			s1_q <= s1_q + SUM1_W'(x_s2);
			s2_q <= s2_q + SUM2_W'(sq_s2);
		end
		if (state_q == ST_MUL) begin
			pns_q <= NUM_W'(s2_q) * NUM_W'(n_q);
			pll_q <= s1_q[SAMPLE_W-1:0] * s1_q[SAMPLE_W-1:0];
			phl_q <= SUM1_W'(s1_q[SUM1_W-1:SAMPLE_W]) * SUM1_W'(s1_q[SAMPLE_W-1:0]);
			phh_q <= s1_q[SUM1_W-1:SAMPLE_W] * s1_q[SUM1_W-1:SAMPLE_W];
			den_q <= DEN_W'(n_q) * DEN_W'(n_q - 1'b1);
		end
		if (state_q == ST_SUB) begin
			num_q <= pns_q - s1sq;
		end
		if (state_q == ST_DIV && div_done) begin
			dev_q <= div_root;
		end
		if (state_q == ST_FIN && out_free) begin
			result_q.deviation    <= dev_q;
			result_q.samples_used <= n_q;
			result_q.status       <= (n_q < CNT_W'(2));
		end
	end

endmodule
